@@ src/grid_dda_raycaster_assert.svh @@
// Assertion macros shared by the checker of the grid raycaster.
`ifndef GRID_DDA_RAYCASTER_ASSERT_SVH
`define GRID_DDA_RAYCASTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/gdr_pkg.sv @@
package gdr_pkg;

	localparam int MAP_SIZE      = 64;
	localparam int SCREEN_HEIGHT = 480;
	localparam int MAX_COLUMNS   = 1024;
	localparam int MAX_STEPS     = 128;

	localparam int MAP_W     = $clog2(MAP_SIZE);
	localparam int IDX_W     = MAP_W + 1;
	localparam int ADDR_W    = 2 * MAP_W;
	localparam int MAP_CELLS = MAP_SIZE * MAP_SIZE;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);

	localparam int POS_W  = 22;
	localparam int FRAC_W = 16;
	localparam int DIR_W  = 16;
	localparam int COLS_W = 11;
	localparam int COL_W  = 10;
	localparam int DIST_W = 32;
	localparam int LINE_W = 9;

	localparam int CAM_W  = 27;
	localparam int PROD_W = DIR_W + CAM_W;
	localparam int SQ_W   = 36;
	localparam int MAG_W  = SQ_W / 2;
	localparam int SUM_W  = 41;
	localparam int LH_W   = $clog2(SCREEN_HEIGHT) + FRAC_W + 1;
	localparam int HALF   = SCREEN_HEIGHT / 2;

	localparam int DIV_NW = POS_W + 1 + 14;
	localparam int DIV_DW = DIST_W;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	localparam int NUM_REGS = 8;
	localparam int APB_AW   = $clog2(NUM_REGS) + 2;
	localparam int APB_DW   = 32;

	localparam logic [2:0] REG_POS_X   = 3'd0;
	localparam logic [2:0] REG_POS_Y   = 3'd1;
	localparam logic [2:0] REG_DIR_X   = 3'd2;
	localparam logic [2:0] REG_DIR_Y   = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;
	localparam logic [2:0] REG_COLS    = 3'd6;
	localparam logic [2:0] REG_MIRROR  = 3'd7;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CAST  = 1'b1;
	localparam logic SIDE_X    = 1'b0;
	localparam logic SIDE_Y    = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [MAP_W-1:0]  cell_row;
		logic [MAP_W-1:0]  cell_col;
		logic              cell_is_wall;
		logic [COL_W-1:0]  screen_column;
	} req_t;

	typedef struct packed {
		logic [COL_W-1:0]  column_out;
		logic [DIST_W-1:0] perp_distance;
		logic              wall_side;
		logic [MAP_W-1:0]  hit_row;
		logic [MAP_W-1:0]  hit_col;
		logic [LINE_W-1:0] line_top;
		logic [LINE_W-1:0] line_bottom;
		logic              no_hit;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quotient;
	} div_rsp_t;

endpackage

@@ src/gdr_ram.sv @@
module gdr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/gdr_div.sv @@
// Restoring divider, one quotient bit per cycle. A zero divisor yields an
// all-ones quotient, which callers treat as saturation.
module gdr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gdr_pkg::div_req_t req,
	output gdr_pkg::div_rsp_t rsp
);

	logic [gdr_pkg::DIV_CW-1:0] cnt_q;
	logic [gdr_pkg::DIV_NW-1:0] quo_q;
	logic [gdr_pkg::DIV_DW-1:0] rem_q;
	logic [gdr_pkg::DIV_DW-1:0] den_q;
	logic                       done_q;
	logic [gdr_pkg::DIV_DW:0]   rem_sh;
	logic                       fits;

	always_comb begin
		rem_sh = {rem_q, quo_q[gdr_pkg::DIV_NW-1]};
		fits   = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= gdr_pkg::DIV_CW'(gdr_pkg::DIV_NW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= cnt_q == gdr_pkg::DIV_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[gdr_pkg::DIV_NW-2:0], fits};
			rem_q <= fits ? gdr_pkg::DIV_DW'(rem_sh - {1'b0, den_q})
			              : rem_sh[gdr_pkg::DIV_DW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ src/grid_dda_raycaster.sv @@
// Grid DDA raycaster.
// Configuration sits behind an APB-style port: eight registers at byte
// addresses 0, 4, ... 28 hold the viewer position, view direction, camera
// plane, column count and mirror flag. pready is always high, and a read
// returns the stored value zero-extended.
// Work enters as one word on req, taken when start is high and busy is low.
// A write word stores one cell of the 64 x 64 wall bitmap in that cycle and
// leaves the block idle, so writes can be issued back to back. A cast word
// walks a ray and produces exactly one result word on res, shown for one
// cycle with res_strobe high; the receiver cannot stall it.
// A cast steps through at most 128 grid cells; a miss skips the last two
// divisions. Time is set by the shared one-bit-per-cycle divider (camera
// offset, two delta distances, and for a hit the perpendicular distance
// and line height), by the square root, and by the single read port of
// the wall bitmap, which is read once per step.
// One cast is in flight at a time; busy stays high until its result cycle.
// After reset the bitmap is cleared to open, one cell per cycle, keeping
// busy high over all 4096 cells; configuration writes are taken meanwhile.
module grid_dda_raycaster (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gdr_pkg::APB_AW-1:0]   paddr,
	input  logic [gdr_pkg::APB_DW-1:0]   pwdata,
	output logic [gdr_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  gdr_pkg::req_t                req,
	output logic                         res_strobe,
	output gdr_pkg::res_t                res
);

	localparam int SW = 5;
	localparam logic [SW-1:0] ST_CLEAR  = 5'd0;
	localparam logic [SW-1:0] ST_IDLE   = 5'd1;
	localparam logic [SW-1:0] ST_CAM    = 5'd2;
	localparam logic [SW-1:0] ST_RAYX   = 5'd3;
	localparam logic [SW-1:0] ST_RAYY   = 5'd4;
	localparam logic [SW-1:0] ST_RAYSUM = 5'd5;
	localparam logic [SW-1:0] ST_SQX    = 5'd6;
	localparam logic [SW-1:0] ST_SQY    = 5'd7;
	localparam logic [SW-1:0] ST_SQINIT = 5'd8;
	localparam logic [SW-1:0] ST_SQRT   = 5'd9;
	localparam logic [SW-1:0] ST_DX     = 5'd10;
	localparam logic [SW-1:0] ST_DY     = 5'd11;
	localparam logic [SW-1:0] ST_SDX    = 5'd12;
	localparam logic [SW-1:0] ST_SDY    = 5'd13;
	localparam logic [SW-1:0] ST_STEP   = 5'd14;
	localparam logic [SW-1:0] ST_LOOK   = 5'd15;
	localparam logic [SW-1:0] ST_PERP   = 5'd16;
	localparam logic [SW-1:0] ST_LH     = 5'd17;
	localparam logic [SW-1:0] ST_OUT    = 5'd18;

	localparam int RW  = gdr_pkg::MAG_W + 3;
	localparam int MW  = gdr_pkg::FRAC_W + 1;
	localparam int SDW = MW + gdr_pkg::DIST_W;
	localparam int SQP = 2 * gdr_pkg::DIR_W;
	localparam logic [gdr_pkg::DIST_W-1:0] SAT = '1;
	localparam logic [gdr_pkg::LH_W-1:0] LH_FULL =
		gdr_pkg::LH_W'(gdr_pkg::SCREEN_HEIGHT) << gdr_pkg::FRAC_W;

	// Configuration registers.
	logic [gdr_pkg::POS_W-1:0]         pos_x_q, pos_y_q;
	logic signed [gdr_pkg::DIR_W-1:0]  dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [gdr_pkg::COLS_W-1:0]        cols_q;
	logic                              mirror_q;

	logic [SW-1:0]                     state_q;
	logic [gdr_pkg::ADDR_W-1:0]        clr_addr_q;
	logic [gdr_pkg::COL_W-1:0]         col_q;
	logic signed [gdr_pkg::CAM_W-1:0]  cam_q;
	logic signed [gdr_pkg::PROD_W-1:0] prod_x_q, prod_y_q;
	logic signed [gdr_pkg::DIR_W-1:0]  rx_q, ry_q;
	logic [2*gdr_pkg::DIR_W-1:0]       sqx_q, sqy_q;
	logic [gdr_pkg::SQ_W-1:0]          rad_q;
	logic [RW-1:0]                     rem_q;
	logic [gdr_pkg::MAG_W-1:0]         root_q;
	logic [gdr_pkg::DIV_CW-1:0]        sq_cnt_q;
	logic [gdr_pkg::DIST_W-1:0]        dx_q, dy_q, perp_q;
	logic [gdr_pkg::SUM_W-1:0]         sdx_q, sdy_q;
	logic [gdr_pkg::IDX_W-1:0]         mx_q, my_q;
	logic [gdr_pkg::STEP_W-1:0]        n_q;
	logic                              side_q;
	logic                              div_go_q;
	logic [gdr_pkg::DIV_NW-1:0]        div_num_q;
	logic [gdr_pkg::DIV_DW-1:0]        div_den_q;
	logic                              strobe_q;
	gdr_pkg::res_t                     res_q;

	gdr_pkg::div_req_t div_req;
	gdr_pkg::div_rsp_t div_rsp;

	logic                              cfg_we;
	logic [2:0]                        cfg_idx;
	logic                              accept;
	logic [gdr_pkg::COLS_W-1:0]        w_eff;
	logic [gdr_pkg::DIR_W-1:0]         abs_rx, abs_ry;
	logic                              rx_pos, ry_pos;
	logic [gdr_pkg::DIST_W-1:0]        q_sat;
	logic signed [gdr_pkg::CAM_W-1:0]  cam_raw;
	logic signed [gdr_pkg::DIR_W-1:0]  rx_new, ry_new;
	logic [RW-1:0]                     rem_sh, trial;
	logic                              sq_fit;
	logic [gdr_pkg::MAG_W-1:0]         mag_next;
	logic [gdr_pkg::FRAC_W-1:0]        frac_x, frac_y;
	logic [MW-1:0]                     mul_x, mul_y;
	logic                              take_x;
	logic [gdr_pkg::IDX_W-1:0]         nmx, nmy;
	logic                              leave;
	logic                              map_we, map_wdata, map_rdata;
	logic [gdr_pkg::ADDR_W-1:0]        map_waddr, map_raddr;
	logic [gdr_pkg::IDX_W-1:0]         edge_idx;
	logic [gdr_pkg::POS_W-1:0]         edge_pos;
	logic signed [gdr_pkg::POS_W+1:0]  num_s;
	logic [gdr_pkg::POS_W:0]           num_abs;
	logic [gdr_pkg::DIR_W-1:0]         perp_den;
	logic [gdr_pkg::LH_W-1:0]          lh;
	logic [gdr_pkg::LH_W-1:0]          half_lo, half_hi;
	logic [gdr_pkg::LINE_W-1:0]        top_v, bot_v;
	gdr_pkg::res_t                     miss_res, hit_res;

	function automatic logic signed [gdr_pkg::DIR_W-1:0] sat16(
		input logic signed [gdr_pkg::PROD_W-1:0] v);
		logic signed [gdr_pkg::PROD_W-1:0] hi, lo;
		hi = gdr_pkg::PROD_W'(32767);
		lo = -gdr_pkg::PROD_W'(32768);
		if (v > hi) begin
			sat16 = 16'sh7FFF;
		end else if (v < lo) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = v[gdr_pkg::DIR_W-1:0];
		end
	endfunction

	// APB register file; writes complete in the access phase.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[gdr_pkg::APB_AW-1:2];
	assign cfg_we  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			dir_x_q   <= 16'sd16384;
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= 16'sd10813;
			cols_q    <= gdr_pkg::COLS_W'(640);
			mirror_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				gdr_pkg::REG_POS_X:   pos_x_q   <= pwdata[gdr_pkg::POS_W-1:0];
				gdr_pkg::REG_POS_Y:   pos_y_q   <= pwdata[gdr_pkg::POS_W-1:0];
				gdr_pkg::REG_DIR_X:   dir_x_q   <= pwdata[gdr_pkg::DIR_W-1:0];
				gdr_pkg::REG_DIR_Y:   dir_y_q   <= pwdata[gdr_pkg::DIR_W-1:0];
				gdr_pkg::REG_PLANE_X: plane_x_q <= pwdata[gdr_pkg::DIR_W-1:0];
				gdr_pkg::REG_PLANE_Y: plane_y_q <= pwdata[gdr_pkg::DIR_W-1:0];
				gdr_pkg::REG_COLS:    cols_q    <= pwdata[gdr_pkg::COLS_W-1:0];
				gdr_pkg::REG_MIRROR:  mirror_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			gdr_pkg::REG_POS_X:   prdata = gdr_pkg::APB_DW'(pos_x_q);
			gdr_pkg::REG_POS_Y:   prdata = gdr_pkg::APB_DW'(pos_y_q);
			gdr_pkg::REG_DIR_X:   prdata = gdr_pkg::APB_DW'($unsigned(dir_x_q));
			gdr_pkg::REG_DIR_Y:   prdata = gdr_pkg::APB_DW'($unsigned(dir_y_q));
			gdr_pkg::REG_PLANE_X: prdata = gdr_pkg::APB_DW'($unsigned(plane_x_q));
			gdr_pkg::REG_PLANE_Y: prdata = gdr_pkg::APB_DW'($unsigned(plane_y_q));
			gdr_pkg::REG_COLS:    prdata = gdr_pkg::APB_DW'(cols_q);
			gdr_pkg::REG_MIRROR:  prdata = gdr_pkg::APB_DW'(mirror_q);
			default:              prdata = '0;
		endcase
	end

	assign busy   = state_q != ST_IDLE;
	assign accept = start & ~busy;

	// Column count is clamped to the supported range; zero counts as one.
	always_comb begin
		if (cols_q == '0) begin
			w_eff = gdr_pkg::COLS_W'(1);
		end else if (cols_q > gdr_pkg::COLS_W'(gdr_pkg::MAX_COLUMNS)) begin
			w_eff = gdr_pkg::COLS_W'(gdr_pkg::MAX_COLUMNS);
		end else begin
			w_eff = cols_q;
		end
	end

	always_comb begin
		rx_pos = !rx_q[gdr_pkg::DIR_W-1] && (rx_q != '0);
		ry_pos = !ry_q[gdr_pkg::DIR_W-1] && (ry_q != '0);
		abs_rx = rx_q[gdr_pkg::DIR_W-1] ? gdr_pkg::DIR_W'(-rx_q) : rx_q;
		abs_ry = ry_q[gdr_pkg::DIR_W-1] ? gdr_pkg::DIR_W'(-ry_q) : ry_q;
		// Quotients above 32 bits (including a zero divisor) saturate.
		q_sat = (div_rsp.quotient > gdr_pkg::DIV_NW'(SAT)) ? SAT
		        : div_rsp.quotient[gdr_pkg::DIST_W-1:0];
		cam_raw = $signed({1'b0, div_rsp.quotient[gdr_pkg::CAM_W-2:0]})
		          - gdr_pkg::CAM_W'(16384);
		rx_new = sat16(gdr_pkg::PROD_W'(dir_x_q) + (prod_x_q >>> 14));
		ry_new = sat16(gdr_pkg::PROD_W'(dir_y_q) + (prod_y_q >>> 14));
	end

	// One digit of the square root per cycle, two radicand bits at a time.
	always_comb begin
		rem_sh   = {rem_q[RW-3:0], rad_q[gdr_pkg::SQ_W-1 -: 2]};
		trial    = RW'({root_q, 2'b01});
		sq_fit   = rem_sh >= trial;
		mag_next = {root_q[gdr_pkg::MAG_W-2:0], sq_fit};
	end

	// Distance to the first grid line: the fraction itself when stepping
	// down, one minus it when stepping up.
	always_comb begin
		frac_x = pos_x_q[gdr_pkg::FRAC_W-1:0];
		frac_y = pos_y_q[gdr_pkg::FRAC_W-1:0];
		mul_x  = rx_pos ? MW'(frac_x) : MW'((MW'(1) << gdr_pkg::FRAC_W) - MW'(frac_x));
		mul_y  = ry_pos ? MW'(frac_y) : MW'((MW'(1) << gdr_pkg::FRAC_W) - MW'(frac_y));
	end

	// DDA step. A step to -1 wraps the unsigned index above the map, so a
	// single compare catches leaving on either side.
	always_comb begin
		take_x = sdx_q < sdy_q;
		nmx    = mx_q;
		nmy    = my_q;
		if (take_x) begin
			nmx = rx_pos ? mx_q - 1'b1 : mx_q + 1'b1;
		end else begin
			nmy = ry_pos ? my_q - 1'b1 : my_q + 1'b1;
		end
		leave     = (nmx >= gdr_pkg::IDX_W'(gdr_pkg::MAP_SIZE))
		         || (nmy >= gdr_pkg::IDX_W'(gdr_pkg::MAP_SIZE));
		map_raddr = {nmx[gdr_pkg::MAP_W-1:0], nmy[gdr_pkg::MAP_W-1:0]};
	end

	// Perpendicular distance numerator from the crossed grid line.
	always_comb begin
		if (side_q == gdr_pkg::SIDE_X) begin
			edge_idx = mx_q + gdr_pkg::IDX_W'(rx_pos);
			edge_pos = pos_x_q;
			perp_den = abs_rx;
		end else begin
			edge_idx = my_q + gdr_pkg::IDX_W'(ry_pos);
			edge_pos = pos_y_q;
			perp_den = abs_ry;
		end
		num_s   = $signed({1'b0, edge_idx, gdr_pkg::FRAC_W'(0)})
		          - $signed({2'b00, edge_pos});
		num_abs = num_s[gdr_pkg::POS_W+1] ? (gdr_pkg::POS_W+1)'(-num_s)
		                                  : num_s[gdr_pkg::POS_W:0];
	end

	// Wall slice span, clamped to the screen.
	always_comb begin
		lh      = (perp_q == '0) ? LH_FULL : div_rsp.quotient[gdr_pkg::LH_W-1:0];
		half_lo = lh >> 1;
		half_hi = gdr_pkg::LH_W'((lh + 1'b1) >> 1);
		if (half_lo >= gdr_pkg::LH_W'(gdr_pkg::SCREEN_HEIGHT - 1 - gdr_pkg::HALF)) begin
			bot_v = gdr_pkg::LINE_W'(gdr_pkg::SCREEN_HEIGHT - 1);
		end else begin
			bot_v = gdr_pkg::LINE_W'(gdr_pkg::HALF) + half_lo[gdr_pkg::LINE_W-1:0];
		end
		if (half_hi >= gdr_pkg::LH_W'(gdr_pkg::HALF)) begin
			top_v = '0;
		end else begin
			top_v = gdr_pkg::LINE_W'(gdr_pkg::HALF) - half_hi[gdr_pkg::LINE_W-1:0];
		end
	end

	// Result words: a walk that ends without a wall reports no hit, a saturated
	// distance and the other hit fields cleared.
	always_comb begin
		miss_res               = '0;
		miss_res.column_out    = col_q;
		miss_res.perp_distance = SAT;
		miss_res.no_hit        = 1'b1;
		hit_res                = '0;
		hit_res.column_out     = col_q;
		hit_res.perp_distance  = perp_q;
		hit_res.wall_side      = side_q;
		hit_res.hit_row        = mx_q[gdr_pkg::MAP_W-1:0];
		hit_res.hit_col        = my_q[gdr_pkg::MAP_W-1:0];
		hit_res.line_top       = top_v;
		hit_res.line_bottom    = bot_v;
		hit_res.no_hit         = 1'b0;
	end

	// Bitmap port: the clearing sweep after reset, else accepted write words.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			map_we    = 1'b1;
			map_waddr = clr_addr_q;
			map_wdata = 1'b0;
		end else begin
			map_we    = accept && (req.req_type == gdr_pkg::REQ_WRITE);
			map_waddr = {req.cell_row, req.cell_col};
			map_wdata = req.cell_is_wall;
		end
	end

	gdr_ram #(
		.WIDTH(1),
		.DEPTH(gdr_pkg::MAP_CELLS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	assign div_req.start    = div_go_q;
	assign div_req.dividend = div_num_q;
	assign div_req.divisor  = div_den_q;

	gdr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			div_go_q   <= 1'b0;
			strobe_q   <= 1'b0;
			n_q        <= '0;
		end else begin
			div_go_q <= 1'b0;
			strobe_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == gdr_pkg::ADDR_W'(gdr_pkg::MAP_CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && req.req_type == gdr_pkg::REQ_CAST) begin
						div_go_q <= 1'b1;
						state_q  <= ST_CAM;
					end
				end
				ST_CAM:    if (div_rsp.done) state_q <= ST_RAYX;
				ST_RAYX:   state_q <= ST_RAYY;
				ST_RAYY:   state_q <= ST_RAYSUM;
				ST_RAYSUM: state_q <= ST_SQX;
				ST_SQX:    state_q <= ST_SQY;
				ST_SQY:    state_q <= ST_SQINIT;
				ST_SQINIT: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (sq_cnt_q == gdr_pkg::DIV_CW'(1)) begin
						div_go_q <= 1'b1;
						state_q  <= ST_DX;
					end
				end
				ST_DX: begin
					if (div_rsp.done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_DY;
					end
				end
				ST_DY:  if (div_rsp.done) state_q <= ST_SDX;
				ST_SDX: state_q <= ST_SDY;
				ST_SDY: begin
					n_q     <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (n_q == gdr_pkg::STEP_W'(gdr_pkg::MAX_STEPS) || leave) begin
						strobe_q <= 1'b1;
						state_q  <= ST_OUT;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (map_rdata) begin
						div_go_q <= 1'b1;
						state_q  <= ST_PERP;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_PERP: begin
					if (div_rsp.done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_LH;
					end
				end
				ST_LH: begin
					if (div_rsp.done) begin
						strobe_q <= 1'b1;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q     <= req.screen_column;
				div_num_q <= gdr_pkg::DIV_NW'({req.screen_column, 15'b0});
				div_den_q <= gdr_pkg::DIV_DW'(w_eff);
			end
			ST_CAM: begin
				cam_q <= mirror_q ? -cam_raw : cam_raw;
			end
			ST_RAYX: prod_x_q <= plane_x_q * cam_q;
			ST_RAYY: prod_y_q <= plane_y_q * cam_q;
			ST_RAYSUM: begin
				rx_q <= rx_new;
				ry_q <= ry_new;
			end
			ST_SQX: sqx_q <= $unsigned(SQP'(rx_q) * SQP'(rx_q));
			ST_SQY: sqy_q <= $unsigned(SQP'(ry_q) * SQP'(ry_q));
			ST_SQINIT: begin
				rad_q    <= gdr_pkg::SQ_W'({1'b0, sqx_q} + {1'b0, sqy_q}) << 4;
				rem_q    <= '0;
				root_q   <= '0;
				sq_cnt_q <= gdr_pkg::DIV_CW'(gdr_pkg::MAG_W);
			end
			ST_SQRT: begin
				rad_q    <= rad_q << 2;
				rem_q    <= sq_fit ? RW'(rem_sh - trial) : rem_sh;
				root_q   <= mag_next;
				sq_cnt_q <= sq_cnt_q - 1'b1;
				div_num_q <= gdr_pkg::DIV_NW'({mag_next, 14'b0});
				div_den_q <= gdr_pkg::DIV_DW'(abs_rx);
			end
			ST_DX: begin
				dx_q      <= q_sat;
				div_den_q <= gdr_pkg::DIV_DW'(abs_ry);
			end
			ST_DY: dy_q <= q_sat;
			ST_SDX: sdx_q <= gdr_pkg::SUM_W'((SDW'(mul_x) * SDW'(dx_q)) >> gdr_pkg::FRAC_W);
			ST_SDY: begin
				sdy_q <= gdr_pkg::SUM_W'((SDW'(mul_y) * SDW'(dy_q)) >> gdr_pkg::FRAC_W);
				mx_q  <= gdr_pkg::IDX_W'(pos_x_q[gdr_pkg::POS_W-1:gdr_pkg::FRAC_W]);
				my_q  <= gdr_pkg::IDX_W'(pos_y_q[gdr_pkg::POS_W-1:gdr_pkg::FRAC_W]);
				side_q <= gdr_pkg::SIDE_X;
			end
			ST_STEP: begin
				if (take_x) begin
					sdx_q  <= sdx_q + gdr_pkg::SUM_W'(dx_q);
					side_q <= gdr_pkg::SIDE_X;
				end else begin
					sdy_q  <= sdy_q + gdr_pkg::SUM_W'(dy_q);
					side_q <= gdr_pkg::SIDE_Y;
				end
				mx_q <= nmx;
				my_q <= nmy;
				// A walk that ends here reports no hit.
				res_q <= miss_res;
			end
			ST_LOOK: begin
				div_num_q <= gdr_pkg::DIV_NW'({num_abs, 14'b0});
				div_den_q <= gdr_pkg::DIV_DW'(perp_den);
			end
			ST_PERP: begin
				perp_q    <= q_sat;
				div_num_q <= gdr_pkg::DIV_NW'(LH_FULL);
				div_den_q <= q_sat;
			end
			ST_LH: res_q <= hit_res;
			default: ;
		endcase
	end

	assign res_strobe = strobe_q;
	assign res        = res_q;

endmodule

@@ src/gdr_checker.sv @@
`include "grid_dda_raycaster_assert.svh"

module gdr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input gdr_pkg::req_t req,
	input logic          res_strobe,
	input gdr_pkg::res_t res
);

	logic acc_write, acc_cast;

	assign acc_write = start && !busy && req.req_type == gdr_pkg::REQ_WRITE;
	assign acc_cast  = start && !busy && req.req_type == gdr_pkg::REQ_CAST;

	`GDR_ASSERT_SAME(a_strobe_busy, res_strobe, busy, "result word outside a cast")
	`GDR_ASSERT_NEXT(a_write_silent, acc_write, !res_strobe && !busy, "write word produced work")
	`GDR_ASSERT_NEXT(a_cast_busy, acc_cast, busy && !res_strobe, "cast did not occupy the block")
	`GDR_ASSERT_NEXT(a_single_word, res_strobe, !res_strobe && !busy, "result word repeated")
	`GDR_ASSERT_SAME(a_nohit_fields, res_strobe && res.no_hit,
		res.perp_distance == '1 && res.line_top == '0 && res.line_bottom == '0,
		"miss result carries hit data")

endmodule

bind grid_dda_raycaster gdr_checker u_gdr_checker (.*);
